[rtl/bbc_pkg.sv]
// Shared constants, types and widths for the bracket balance checker.
package bbc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int LINE_BITS   = 16;
    localparam int OUT_LINE_W  = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [1:0] {
        BK_NONE   = 2'd0,
        BK_BRACE  = 2'd1,
        BK_PAREN  = 2'd2,
        BK_SQUARE = 2'd3
    } t_bkind;

    typedef enum logic [2:0] {
        V_PASS      = 3'd0,
        V_CLOSE     = 3'd1,
        V_MISMATCH  = 3'd2,
        V_UNCLOSED  = 3'd3,
        V_OVERFLOW  = 3'd4
    } t_verdict;

    typedef struct packed {
        t_bkind                kind;
        logic [LINE_BITS-1:0]  line;
    } t_entry;

endpackage

[rtl/bbc_if.sv]
// Valid/ready channel interfaces for character input and verdict output.
interface bbc_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] character;

    modport source (output valid, output kind, output character, input ready);
    modport sink   (input valid, input kind, input character, output ready);
endinterface

interface bbc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [15:0] error_line;
    logic [1:0]  open_bracket;

    modport source (output valid, output verdict, output error_line,
                    output open_bracket, input ready);
    modport sink   (input valid, input verdict, input error_line,
                    input open_bracket, output ready);
endinterface

[rtl/bracket_balance_checker.sv]
// Bracket balance checker: stage input, update stack and flags, hold verdict.
//
// Usage: characters enter on i_in with kind = 0, one transfer each; a transfer
// with kind = 1 marks end of text and produces exactly one verdict transfer on
// o_out (verdict, error_line, open_bracket). Character transfers produce none.
// Throughput is one input transfer per cycle unless an end-of-text item is held
// in the input register (see below); the bracket stack keeps its top entry in
// flip-flops and prefetches the entry below it from the stack memory, so a push
// or pop every cycle needs only one memory write or one registered read. After
// the end-of-text transfer the item passes through the input register, then its
// verdict is loaded into the result register, which drives o_out.valid.
// While a verdict waits on o_out, characters keep flowing; only a second
// end-of-text item stalls in the input register until the receiver takes the
// pending verdict, and i_in.ready then falls once that register is full.
// Reset (i_rst_n low at a clock edge) empties the stack, sets the line counter
// to 1, clears the string/escape flags and the recorded error, and drops any
// staged input or pending verdict. Stack memory contents are not cleared; the
// fill count alone tells which entries are live. After each verdict the block
// returns to the same state for the next text.
module bracket_balance_checker
    import bbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bbc_in_if.sink      i_in,
    bbc_out_if.source   o_out
);

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    // input register
    logic                  r_in_valid;
    logic                  r_in_kind;
    logic [7:0]            r_in_char;

    // checker state
    logic [CNT_W-1:0]      r_count,    n_count;
    t_entry                r_top,      n_top;
    t_entry                r_below;
    logic [LINE_BITS-1:0]  r_line,     n_line;
    logic                  r_in_str,   n_in_str;
    logic                  r_esc,      n_esc;
    t_verdict              r_verdict,  n_verdict;
    logic [LINE_BITS-1:0]  r_err_line, n_err_line;

    t_entry                r_stack [STACK_DEPTH];

    // result register
    logic                  r_out_valid;
    t_verdict              r_out_verdict, n_out_verdict;
    logic [OUT_LINE_W-1:0] r_out_line,    n_out_line;
    t_bkind                r_out_bkind,   n_out_bkind;

    logic                  out_free;
    logic                  s1_fire;
    logic                  do_push;
    logic                  do_pop;
    logic                  end_fire;
    t_bkind                open_k;
    t_bkind                close_k;
    logic [CNT_W-1:0]      rd_cnt;
    logic [CNT_W-1:0]      wr_cnt;

    function automatic logic [OUT_LINE_W-1:0] f_sat_line(input logic [LINE_BITS-1:0] l);
        logic [LINE_BITS+OUT_LINE_W-1:0] w;
        w = {{OUT_LINE_W{1'b0}}, l};
        if (|w[LINE_BITS+OUT_LINE_W-1:OUT_LINE_W]) begin
            return {OUT_LINE_W{1'b1}};
        end
        return w[OUT_LINE_W-1:0];
    endfunction

    assign out_free    = !r_out_valid || o_out.ready;
    assign s1_fire     = r_in_valid && ((r_in_kind == KIND_CHAR) || out_free);
    assign end_fire    = s1_fire && (r_in_kind == KIND_END);
    assign i_in.ready  = !r_in_valid || s1_fire;

    assign o_out.valid        = r_out_valid;
    assign o_out.verdict      = r_out_verdict;
    assign o_out.error_line   = r_out_line;
    assign o_out.open_bracket = r_out_bkind;

    always_comb begin
        unique case (r_in_char)
            CH_LBRACE: open_k = BK_BRACE;
            CH_LPAREN: open_k = BK_PAREN;
            CH_LBRACK: open_k = BK_SQUARE;
            default:   open_k = BK_NONE;
        endcase
        unique case (r_in_char)
            CH_RBRACE: close_k = BK_BRACE;
            CH_RPAREN: close_k = BK_PAREN;
            CH_RBRACK: close_k = BK_SQUARE;
            default:   close_k = BK_NONE;
        endcase
    end

    always_comb begin
        n_count       = r_count;
        n_top         = r_top;
        n_line        = r_line;
        n_in_str      = r_in_str;
        n_esc         = r_esc;
        n_verdict     = r_verdict;
        n_err_line    = r_err_line;
        n_out_verdict = V_PASS;
        n_out_line    = '0;
        n_out_bkind   = BK_NONE;
        do_push       = 1'b0;
        do_pop        = 1'b0;

        if (r_verdict != V_PASS) begin
            n_out_verdict = r_verdict;
            n_out_line    = f_sat_line(r_err_line);
        end else if (r_count != '0) begin
            n_out_verdict = V_UNCLOSED;
            n_out_line    = f_sat_line(r_top.line);
            n_out_bkind   = r_top.kind;
        end

        if (s1_fire) begin
            if (r_in_kind == KIND_END) begin
                // start over for the next text
                n_count    = '0;
                n_line     = LINE_BITS'(1);
                n_in_str   = 1'b0;
                n_esc      = 1'b0;
                n_verdict  = V_PASS;
                n_err_line = '0;
            end else if (r_in_char == CH_NL) begin
                if (r_line != LINE_MAX) begin
                    n_line = r_line + LINE_BITS'(1);
                end
                n_in_str = 1'b0;
                n_esc    = 1'b0;
            end else begin
                if (r_in_char == CH_QUOTE && !r_esc) begin
                    n_in_str = !r_in_str;
                end
                n_esc = (r_in_char == CH_BSLASH) && !r_esc;
                if (!n_in_str && r_verdict == V_PASS) begin
                    if (open_k != BK_NONE) begin
                        if (r_count == CNT_W'(STACK_DEPTH)) begin
                            n_verdict  = V_OVERFLOW;
                            n_err_line = r_line;
                        end else begin
                            do_push    = 1'b1;
                            n_top.kind = open_k;
                            n_top.line = r_line;
                            n_count    = r_count + CNT_W'(1);
                        end
                    end else if (close_k != BK_NONE) begin
                        if (r_count == '0) begin
                            n_verdict  = V_CLOSE;
                            n_err_line = r_line;
                        end else if (r_top.kind != close_k) begin
                            n_verdict  = V_MISMATCH;
                            n_err_line = r_line;
                        end else begin
                            do_pop  = 1'b1;
                            n_top   = r_below;
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                end
            end
        end
    end

    // old top goes to memory slot count-1; prefetch slot count-3 on pop
    assign wr_cnt = r_count - CNT_W'(1);
    assign rd_cnt = r_count - CNT_W'(3);

    always_ff @(posedge i_clk) begin
        if (do_push && r_count != '0) begin
            r_stack[wr_cnt[ADDR_W-1:0]] <= r_top;
        end
        if (do_push) begin
            r_below <= r_top;
        end else if (do_pop) begin
            r_below <= r_stack[rd_cnt[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_line      <= LINE_BITS'(1);
            r_in_str    <= 1'b0;
            r_esc       <= 1'b0;
            r_verdict   <= V_PASS;
            r_err_line  <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (end_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_count    <= n_count;
            r_line     <= n_line;
            r_in_str   <= n_in_str;
            r_esc      <= n_esc;
            r_verdict  <= n_verdict;
            r_err_line <= n_err_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_kind <= i_in.kind;
            r_in_char <= i_in.character;
        end
        r_top <= n_top;
        if (end_fire) begin
            r_out_verdict <= n_out_verdict;
            r_out_line    <= n_out_line;
            r_out_bkind   <= n_out_bkind;
        end
    end

endmodule
